// ----- sv/tiedil_pkg.sv -----
// Shared types and constants of the texture island edge dilation block.
// No dependencies; every other file imports it.
package tiedil_pkg;

  localparam int IDX_W     = 18;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int SUM_W     = 11;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 10;
  localparam int PASS_W    = 4;
  localparam int MIN_SIDE  = 32;
  localparam int DIV_STEPS = SUM_W;

  localparam logic [CH_W-1:0] ALPHA_ON = 8'd255;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic CFG_IMAGE_SIZE     = 1'b0;
  localparam logic CFG_PADDING_PASSES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_CADDR,
    ST_CREAD,
    ST_CEVAL,
    ST_NADDR,
    ST_NREAD,
    ST_NACC,
    ST_DIV,
    ST_WRITE,
    ST_NEXT
  } state_t;

  typedef struct packed {
    logic start_run;
    logic pass_begin;
    logic addr_load;
    logic center_hold;
    logic acc;
    logic div_step;
    logic wr_texel;
    logic texel_next;
    logic pass_end;
  } cmd_t;

  typedef struct packed {
    logic center_cov;
    logic n_zero;
    logic div_done;
    logic nb_last;
    logic texel_last;
    logic pass_zero;
  } sts_t;

endpackage

// ----- sv/tiedil_ctrl.sv -----
// Pass sequencer of the dilation block: walks passes, texels and neighbors.
// Depends on tiedil_pkg; drives the datapath through cmd_t, reads sts_t.
module tiedil_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  input  tiedil_pkg::sts_t  sts,
  output tiedil_pkg::cmd_t  cmd,
  output logic              busy
);
  import tiedil_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_func == FUNC_RUN) begin
          cmd.start_run = 1'b1;
          state_nxt     = ST_PASS;
        end
      end
      ST_PASS: begin
        if (sts.pass_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.pass_begin = 1'b1;
          state_nxt      = ST_CADDR;
        end
      end
      ST_CADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt     = ST_CREAD;
      end
      ST_CREAD: state_nxt = ST_CEVAL;
      ST_CEVAL: begin
        cmd.center_hold = 1'b1;
        state_nxt       = sts.center_cov ? ST_WRITE : ST_NADDR;
      end
      ST_NADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt     = ST_NREAD;
      end
      ST_NREAD: state_nxt = ST_NACC;
      ST_NACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.nb_last ? ST_DIV : ST_NADDR;
      end
      ST_DIV: begin
        if (sts.n_zero || sts.div_done) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.wr_texel = 1'b1;
        state_nxt    = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.texel_next = 1'b1;
        if (sts.texel_last) begin
          cmd.pass_end = 1'b1;
          state_nxt    = ST_PASS;
        end else begin
          state_nxt = ST_CADDR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/tiedil_dp.sv -----
// Datapath of the dilation block: configuration, texel stores, neighbor
// walk counters, accumulators and mean divider. Depends on tiedil_pkg.
module tiedil_dp #(
  parameter int MAX_SIDE   = 512,
  parameter int MAX_PASSES = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tiedil_pkg::cmd_t              cmd,
  output tiedil_pkg::sts_t              sts,
  input  logic                          busy,
  input  logic                          in_accept,
  input  logic [1:0]                    in_func,
  input  logic [tiedil_pkg::IDX_W-1:0]  in_texel_index,
  input  logic [tiedil_pkg::CH_W-1:0]   in_red_in,
  input  logic [tiedil_pkg::CH_W-1:0]   in_green_in,
  input  logic [tiedil_pkg::CH_W-1:0]   in_blue_in,
  input  logic                          in_covered_in,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tiedil_pkg::CFG_W-1:0]  cfg_data,
  output logic                          out_valid,
  output logic [tiedil_pkg::CH_W-1:0]   out_red_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_green_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_blue_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_alpha_out,
  output logic                          out_covered_out
);
  import tiedil_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = XW + SW;
  localparam int RST_SIDE = (MAX_SIDE < 512) ? MAX_SIDE : 512;

  logic [COLOR_W-1:0] color_mem [DEPTH];
  logic               mask_a_mem [DEPTH];
  logic               mask_b_mem [DEPTH];

  logic [SW-1:0]     side_r;
  logic [PASS_W-1:0] passes_r, pass_cnt_r;
  logic              bank_r;
  logic [XW-1:0]     x_r, y_r;
  logic [1:0]        dxi_r, dyi_r;
  logic [AW-1:0]     addr_r, center_r;
  logic              inb_r, cov_hold_r;
  logic [COLOR_W-1:0] col_q_r;
  logic              ma_q_r, mb_q_r;
  logic [SUM_W-1:0]  num_r [3];
  logic [CNT_W-1:0]  rem_r [3];
  logic [CNT_W-1:0]  n_r, div_cnt_r;
  logic              out_valid_r, oor_r;

  logic [2*SW-1:0]   total;
  logic              idx_ok;
  logic [SW-1:0]     side_sat;
  logic [PASS_W-1:0] passes_sat;
  logic signed [XW+1:0] nx_s, ny_s;
  logic              inb;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     addr_calc, rd_addr, in_addr, wr_addr;
  logic              mcur;
  logic              fill;
  logic              col_we, ma_we, mb_we, ma_wd, mb_wd;
  logic [COLOR_W-1:0] col_wd;
  logic [CH_W-1:0]   ch_q [3];

  assign total  = (2*SW)'(side_r) * (2*SW)'(side_r);
  assign idx_ok = 32'(in_texel_index) < 32'(total);
  assign in_addr = AW'(in_texel_index);

  always_comb begin
    priority if (cfg_data < CFG_W'(MIN_SIDE)) begin
      side_sat = SW'(MIN_SIDE);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_sat = SW'(MAX_SIDE);
    end else begin
      side_sat = SW'(cfg_data);
    end
    if (32'(cfg_data[PASS_W-1:0]) > MAX_PASSES) begin
      passes_sat = PASS_W'(MAX_PASSES);
    end else begin
      passes_sat = cfg_data[PASS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SW'(RST_SIDE);
      passes_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_SIZE) begin
        side_r <= side_sat;
      end
      if (cfg_index == CFG_PADDING_PASSES) begin
        passes_r <= passes_sat;
      end
    end
  end

  assign nx_s = $signed({2'b00, x_r}) + $signed({{XW{1'b0}}, dxi_r}) - 1;
  assign ny_s = $signed({2'b00, y_r}) + $signed({{XW{1'b0}}, dyi_r}) - 1;
  assign inb  = (nx_s >= 0) && (ny_s >= 0) &&
                (nx_s < $signed((XW+2)'(side_r))) && (ny_s < $signed((XW+2)'(side_r)));
  assign prod = PW'(ny_s[XW-1:0]) * PW'(side_r);
  assign addr_calc = AW'(prod + PW'(nx_s[XW-1:0]));

  assign rd_addr = busy ? addr_r : in_addr;
  assign mcur    = bank_r ? mb_q_r : ma_q_r;
  assign fill    = !cov_hold_r && (n_r != '0);

  always_comb begin
    col_we  = 1'b0;
    ma_we   = 1'b0;
    mb_we   = 1'b0;
    ma_wd   = in_covered_in;
    mb_wd   = in_covered_in;
    wr_addr = in_addr;
    col_wd  = {in_red_in, in_green_in, in_blue_in};
    if (busy) begin
      wr_addr = center_r;
      col_wd  = {num_r[0][CH_W-1:0], num_r[1][CH_W-1:0], num_r[2][CH_W-1:0]};
      ma_wd   = cov_hold_r || fill;
      mb_wd   = cov_hold_r || fill;
      col_we  = cmd.wr_texel && fill;
      ma_we   = cmd.wr_texel && bank_r;
      mb_we   = cmd.wr_texel && !bank_r;
    end else if (in_accept && in_func == FUNC_LOAD && idx_ok) begin
      col_we = 1'b1;
      ma_we  = 1'b1;
      mb_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      color_mem[wr_addr] <= col_wd;
    end
    if (ma_we) begin
      mask_a_mem[wr_addr] <= ma_wd;
    end
    if (mb_we) begin
      mask_b_mem[wr_addr] <= mb_wd;
    end
    col_q_r <= color_mem[rd_addr];
    ma_q_r  <= mask_a_mem[rd_addr];
    mb_q_r  <= mask_b_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      pass_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_accept && in_func == FUNC_READ;
      if (cmd.start_run) begin
        pass_cnt_r <= passes_r;
      end else if (cmd.pass_end) begin
        pass_cnt_r <= pass_cnt_r - 1'b1;
        bank_r     <= !bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    oor_r <= !idx_ok;
    if (cmd.pass_begin) begin
      x_r   <= '0;
      y_r   <= '0;
      dxi_r <= 2'd1;
      dyi_r <= 2'd1;
    end
    if (cmd.addr_load) begin
      addr_r <= addr_calc;
      inb_r  <= inb;
    end
    if (cmd.center_hold) begin
      center_r   <= addr_r;
      cov_hold_r <= mcur;
      dxi_r      <= '0;
      dyi_r      <= '0;
      n_r        <= '0;
      div_cnt_r  <= '0;
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= '0;
        rem_r[c] <= '0;
      end
    end
    if (cmd.acc) begin
      if (inb_r && mcur) begin
        n_r      <= n_r + 1'b1;
        num_r[0] <= num_r[0] + SUM_W'(col_q_r[3*CH_W-1:2*CH_W]);
        num_r[1] <= num_r[1] + SUM_W'(col_q_r[2*CH_W-1:CH_W]);
        num_r[2] <= num_r[2] + SUM_W'(col_q_r[CH_W-1:0]);
      end
      if (dxi_r == 2'd2) begin
        dxi_r <= '0;
        dyi_r <= dyi_r + 1'b1;
      end else begin
        dxi_r <= dxi_r + 1'b1;
      end
    end
    if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      for (int c = 0; c < 3; c++) begin
        if ({rem_r[c], num_r[c][SUM_W-1]} >= {1'b0, n_r}) begin
          rem_r[c] <= CNT_W'({rem_r[c], num_r[c][SUM_W-1]} - {1'b0, n_r});
          num_r[c] <= {num_r[c][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[c] <= CNT_W'({rem_r[c], num_r[c][SUM_W-1]});
          num_r[c] <= {num_r[c][SUM_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.texel_next) begin
      dxi_r <= 2'd1;
      dyi_r <= 2'd1;
      if (x_r == XW'(side_r - 1'b1)) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  assign sts.center_cov = mcur;
  assign sts.n_zero     = (n_r == '0);
  assign sts.div_done   = (div_cnt_r == CNT_W'(DIV_STEPS));
  assign sts.nb_last    = (dxi_r == 2'd2) && (dyi_r == 2'd2);
  assign sts.texel_last = (x_r == XW'(side_r - 1'b1)) && (y_r == XW'(side_r - 1'b1));
  assign sts.pass_zero  = (pass_cnt_r == '0);

  assign ch_q[0] = col_q_r[3*CH_W-1:2*CH_W];
  assign ch_q[1] = col_q_r[2*CH_W-1:CH_W];
  assign ch_q[2] = col_q_r[CH_W-1:0];

  assign out_valid       = out_valid_r;
  assign out_red_out     = oor_r ? '0 : ch_q[0];
  assign out_green_out   = oor_r ? '0 : ch_q[1];
  assign out_blue_out    = oor_r ? '0 : ch_q[2];
  assign out_covered_out = !oor_r && mcur;
  assign out_alpha_out   = out_covered_out ? ALPHA_ON : '0;

endmodule

// ----- sv/texture_island_edge_dilation_core.sv -----
// Top level of the texture island edge dilation block.
// Depends on tiedil_pkg, tiedil_ctrl and tiedil_dp.
//
// Command channel: a transaction is taken at a clock edge with start high and
// busy low. func load writes one texel (RGB and coverage) at a flat index,
// func read returns that texel, func run performs the configured number of
// dilation passes over the image_size x image_size texture.
// Load and read may follow every cycle. A read result appears in the cycle
// after acceptance, for one cycle, with out_valid high; the receiver cannot
// stall it. Out-of-image reads return zeros.
// A run holds busy high until its last pass ends. In each pass a covered texel
// is kept; any other texel makes nine neighbor reads through one registered
// memory port, then, if a neighbor is covered, runs a bit-serial 11-step mean
// divider and fills the texel with the mean.
// Configuration: cfg_valid/cfg_ready write channel, index 0 image_size
// (saturated to 32..MAX_SIDE), index 1 padding_passes; always ready.
// Reset clears the controller, out_valid and the configuration and pass registers
// (image_size 512 or MAX_SIDE if smaller, passes 0); texel stores are undefined until loaded.
module texture_island_edge_dilation_core #(
  parameter int MAX_SIDE   = 512,
  parameter int MAX_PASSES = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [tiedil_pkg::IDX_W-1:0]  in_texel_index,
  input  logic [tiedil_pkg::CH_W-1:0]   in_red_in,
  input  logic [tiedil_pkg::CH_W-1:0]   in_green_in,
  input  logic [tiedil_pkg::CH_W-1:0]   in_blue_in,
  input  logic                          in_covered_in,
  output logic                          out_valid,
  output logic [tiedil_pkg::CH_W-1:0]   out_red_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_green_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_blue_out,
  output logic [tiedil_pkg::CH_W-1:0]   out_alpha_out,
  output logic                          out_covered_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tiedil_pkg::CFG_W-1:0]  cfg_data
);
  import tiedil_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  tiedil_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  tiedil_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_PASSES (MAX_PASSES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .busy            (busy),
    .in_accept       (in_accept),
    .in_func         (in_func),
    .in_texel_index  (in_texel_index),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_covered_in   (in_covered_in),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_alpha_out   (out_alpha_out),
    .out_covered_out (out_covered_out)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for texture_island_edge_dilation_core.
// Depends on tiedil_pkg and the core RTL; a scoreboard class predicts every
// read from loads, dilation runs and configuration writes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tiedil_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 512 * 512;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
    bit       covered;
  } texel_read_t;

  class texel_scoreboard;
    bit [23:0]   colors [STORE_DEPTH];
    bit          mask [STORE_DEPTH];
    int unsigned side = 512;
    int unsigned passes = 0;
    texel_read_t pending_reads [$];
    int          errors = 0;

    function void write_reg(bit idx, bit [9:0] data);
      if (idx == CFG_IMAGE_SIZE) side = data < 32 ? 32 : (data > 512 ? 512 : data);
      else passes = data[3:0];
    endfunction

    function void dilate_once();
      int unsigned total;
      bit          grown [];
      int unsigned r, g, b, n;
      int          nx, ny;
      total = side * side;
      grown = new[total];
      for (int i = 0; i < total; i++) grown[i] = mask[i];
      for (int y = 0; y < side; y++) begin
        for (int x = 0; x < side; x++) begin
          if (mask[y * side + x]) continue;
          r = 0; g = 0; b = 0; n = 0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              nx = x + dx;
              ny = y + dy;
              if (nx < 0 || ny < 0 || nx >= side || ny >= side) continue;
              if (!mask[ny * side + nx]) continue;
              r += colors[ny * side + nx][23:16];
              g += colors[ny * side + nx][15:8];
              b += colors[ny * side + nx][7:0];
              n++;
            end
          end
          if (n == 0) continue;
          colors[y * side + x] = {8'(r / n), 8'(g / n), 8'(b / n)};
          grown[y * side + x] = 1'b1;
        end
      end
      for (int i = 0; i < total; i++) mask[i] = grown[i];
    endfunction

    function void note_item(bit [1:0] func, bit [17:0] idx, bit [7:0] r, bit [7:0] g,
                            bit [7:0] b, bit cov);
      texel_read_t t;
      case (func)
        FUNC_LOAD: begin
          if (idx < side * side) begin
            colors[idx] = {r, g, b};
            mask[idx] = cov;
          end
        end
        FUNC_RUN: begin
          for (int p = 0; p < passes; p++) dilate_once();
        end
        FUNC_READ: begin
          t = '{0, 0, 0, 0, 0};
          if (idx < side * side) begin
            {t.red, t.green, t.blue} = colors[idx];
            t.covered = mask[idx];
            t.alpha = mask[idx] ? 8'd255 : 8'd0;
          end
          pending_reads.push_back(t);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_texel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a, bit cov);
      texel_read_t t;
      if (pending_reads.size() == 0) begin
        report("read result with no read outstanding");
        return;
      end
      t = pending_reads.pop_front();
      if (r != t.red) report($sformatf("red %0d, want %0d", r, t.red));
      if (g != t.green) report($sformatf("green %0d, want %0d", g, t.green));
      if (b != t.blue) report($sformatf("blue %0d, want %0d", b, t.blue));
      if (a != t.alpha) report($sformatf("alpha %0d, want %0d", a, t.alpha));
      if (cov != t.covered) report($sformatf("covered %0d, want %0d", cov, t.covered));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [17:0] in_texel_index;
  logic [7:0]  in_red_in, in_green_in, in_blue_in;
  logic        in_covered_in;
  logic        out_valid;
  logic [7:0]  out_red_out, out_green_out, out_blue_out, out_alpha_out;
  logic        out_covered_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [9:0]  cfg_data;

  texel_scoreboard sb = new();
  bit          written [STORE_DEPTH];
  int unsigned loaded_list [$];
  int unsigned cur_side = 512;
  int          idle_pct = 0;

  texture_island_edge_dilation_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_item(in_func, in_texel_index, in_red_in, in_green_in, in_blue_in,
                   in_covered_in);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && out_valid)
      sb.check_texel(out_red_out, out_green_out, out_blue_out, out_alpha_out,
                     out_covered_out);
  end

  task automatic send_item(logic [1:0] func, logic [17:0] idx, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b, logic cov);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_texel_index <= idx;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_covered_in <= cov;
    do @(posedge clk); while (busy);
    if (func == FUNC_LOAD && idx < cur_side * cur_side && !written[idx]) begin
      written[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic load_texel(int unsigned idx, int density);
    send_item(FUNC_LOAD, idx, $urandom, $urandom, $urandom, $urandom_range(99) < density);
  endtask

  task automatic read_random();
    int unsigned total;
    int unsigned idx;
    total = cur_side * cur_side;
    if (total < STORE_DEPTH && $urandom_range(3) == 0) begin
      idx = $urandom_range(STORE_DEPTH - 1, total);
    end else begin
      do idx = loaded_list[$urandom_range(loaded_list.size() - 1)]; while (idx >= total);
    end
    send_item(FUNC_READ, idx, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || sb.pending_reads.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMAGE_SIZE) cur_side = data < 32 ? 32 : (data > 512 ? 512 : data);
  endtask

  task automatic fill_and_run(logic [9:0] size_val, logic [3:0] npass, int density);
    write_cfg(CFG_IMAGE_SIZE, size_val);
    write_cfg(CFG_PADDING_PASSES, npass);
    for (int i = 0; i < 1024; i++) begin
      load_texel(i, density);
      if ($urandom_range(7) == 0) read_random();
      if ($urandom_range(63) == 0)
        send_item(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(63) == 0) load_texel($urandom_range(STORE_DEPTH - 1, 1024), 50);
    end
    send_item(FUNC_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (60) read_random();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOAD;
    in_texel_index = '0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_covered_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_SIZE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(CFG_IMAGE_SIZE, 10'd0);
    write_cfg(CFG_PADDING_PASSES, 4'd1);
    send_item(FUNC_LOAD, 0, 8'hff, 8'hff, 8'hff, 1'b1);
    send_item(FUNC_LOAD, 1023, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(FUNC_LOAD, 18'h3ffff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_item(FUNC_UNUSED, 18'h3ffff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_item(FUNC_READ, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 1023, 0, 0, 0, 0);
    send_item(FUNC_READ, 1024, 0, 0, 0, 0);
    send_item(FUNC_READ, 18'h3ffff, 8'hff, 8'hff, 8'hff, 1'b1);
    for (int i = 1; i < 1023; i++) load_texel(i, (i % 97 == 0) ? 100 : 0);
    send_item(FUNC_RUN, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_item(FUNC_READ, i * 131, 0, 0, 0, 0);
    drain();

    write_cfg(CFG_PADDING_PASSES, 4'd0);
    send_item(FUNC_RUN, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 1, 0, 0, 0, 0);
    drain();

    idle_pct = 0;
    fill_and_run(10'd32, 4'd2, 10);
    idle_pct = 50;
    fill_and_run($urandom_range(32), 4'd15, 40);
    idle_pct = 9;
    fill_and_run(10'd31, 4'($urandom_range(1, 3)), 20);

    write_cfg(CFG_IMAGE_SIZE, 10'd1023);
    write_cfg(CFG_PADDING_PASSES, 4'd0);
    for (int i = 0; i < 200; i++) begin
      load_texel((i == 0) ? STORE_DEPTH - 1 : $urandom_range(STORE_DEPTH - 1), 50);
      if ($urandom_range(1) == 0) read_random();
    end
    send_item(FUNC_RUN, 0, 0, 0, 0, 0);
    repeat (40) read_random();
    drain();

    idle_pct = 50;
    write_cfg(CFG_IMAGE_SIZE, 10'd100);
    repeat (100) begin
      load_texel($urandom_range(100 * 100 - 1), 50);
      read_random();
    end
    drain();

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
